// ----- rtl/core/kvs_pkg.sv -----
`timescale 1ns / 1ps

package kvs_pkg;

	// table geometry
	localparam int MAX_KEYS = 64;
	localparam int KEY_AW   = $clog2(MAX_KEYS);
	localparam int NUM_W    = KEY_AW + 1;

	// field widths
	localparam int CNT_W  = 7;
	localparam int SLOT_W = 6;
	localparam int TIME_W = 32;
	localparam int VAL_W  = 32;
	localparam int W_W    = 16;
	localparam int DIV_CW = $clog2(W_W);
	localparam int NCOMP  = 3;
	localparam int COMP_W = 2;
	localparam int DIFF_W = VAL_W + 1;
	localparam int PROD_W = DIFF_W + W_W + 1;

	// operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		ST_INTERP = 2'd0,
		ST_BEFORE = 2'd1,
		ST_AFTER  = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK0,
		S_SCAN,
		S_DIV,
		S_VA,
		S_VB,
		S_VW,
		S_MUL,
		S_FIN,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              key_wr;
		logic              start;
		logic              clr_res;
		logic              t_rd;
		logic              v_rd;
		logic [KEY_AW-1:0] rd_addr;
		logic              prev_ld;
		logic              div_init;
		logic              div_step;
		logic              va_ld;
		logic              vb_ld;
		logic              mul_en;
		logic [COMP_W-1:0] comp;
		logic              out_load;
		logic [SLOT_W-1:0] out_slot;
		status_t           out_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic le_first;
		logic hit;
	} sts_t;

endpackage

// ----- rtl/core/kvs_in_if.sv -----
`timescale 1ns / 1ps

interface kvs_in_if;
	logic                             valid;
	logic                             ready;
	logic                             operation;
	logic [kvs_pkg::SLOT_W-1:0]       key_index;
	logic [kvs_pkg::TIME_W-1:0]       time_value;
	logic signed [kvs_pkg::VAL_W-1:0] value_x;
	logic signed [kvs_pkg::VAL_W-1:0] value_y;
	logic signed [kvs_pkg::VAL_W-1:0] value_z;

	modport source (
		output valid, operation, key_index, time_value, value_x, value_y, value_z,
		input  ready
	);
	modport sink (
		input  valid, operation, key_index, time_value, value_x, value_y, value_z,
		output ready
	);
endinterface

// ----- rtl/core/kvs_out_if.sv -----
`timescale 1ns / 1ps

interface kvs_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [kvs_pkg::VAL_W-1:0] result_x;
	logic signed [kvs_pkg::VAL_W-1:0] result_y;
	logic signed [kvs_pkg::VAL_W-1:0] result_z;
	logic [kvs_pkg::SLOT_W-1:0]       lower_slot;
	logic [1:0]                       status;

	modport source (
		output valid, result_x, result_y, result_z, lower_slot, status,
		input  ready
	);
	modport sink (
		input  valid, result_x, result_y, result_z, lower_slot, status,
		output ready
	);
endinterface

// ----- rtl/core/keyframe_vector_sampler.sv -----
`timescale 1ns / 1ps

// Keyframe vector sampler. Holds up to 64 keys (time Q24.8, xyz vector Q16.16),
// written one per transaction with operation 0; key_count sets how many slots
// from zero are live. A sample transaction (operation 1) scans the keys in order,
// one key per cycle through the time memory's single read port, finds the first
// segment with t_i <= time < t_i+1, forms the Q0.16 weight in a 16-step serial
// divider and blends the three components through one shared multiplier. A
// finished result sits in the output register while the next transaction is taken.

module keyframe_vector_sampler (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [kvs_pkg::CNT_W-1:0] cfg_data,
	kvs_in_if.sink                    key_in,
	kvs_out_if.source                 sample_out
);

	kvs_pkg::cmd_t cmd;
	kvs_pkg::sts_t sts;
	logic          in_ready;
	logic          out_valid;

	assign key_in.ready     = in_ready;
	assign sample_out.valid = out_valid;

	// sequencer
	kvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (key_in.valid),
		.in_op     (key_in.operation),
		.in_ready  (in_ready),
		.out_ready (sample_out.ready),
		.out_valid (out_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// key memories, divider and blend
	kvs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.key_index  (key_in.key_index),
		.time_value (key_in.time_value),
		.value_x    (key_in.value_x),
		.value_y    (key_in.value_y),
		.value_z    (key_in.value_z),
		.result_x   (sample_out.result_x),
		.result_y   (sample_out.result_y),
		.result_z   (sample_out.result_z),
		.lower_slot (sample_out.lower_slot),
		.status     (sample_out.status)
	);

	// empty table answers a zero vector at slot zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sample_out.valid && (sample_out.status == kvs_pkg::ST_EMPTY) |->
		(sample_out.result_x == '0) && (sample_out.result_y == '0) &&
		(sample_out.result_z == '0) && (sample_out.lower_slot == '0))
		else $error("empty-table result not zero");

	// clamp before the first key always uses slot zero
	a_before_slot: assert property (@(posedge clk) disable iff (!arst_n)
		sample_out.valid && (sample_out.status == kvs_pkg::ST_BEFORE) |->
		(sample_out.lower_slot == '0))
		else $error("clamp-before result not on slot zero");

	// a sample keeps the block busy for at least the next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		key_in.valid && key_in.ready && (key_in.operation == kvs_pkg::OP_SAMPLE) |=>
		!key_in.ready)
		else $error("input taken while a sample is in flight");

	// a key write does not stall the input: it stays ready in the next cycle
	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		key_in.valid && key_in.ready && (key_in.operation == kvs_pkg::OP_WRITE) |=>
		key_in.ready)
		else $error("key write stalled the input");

endmodule

// ----- rtl/core/kvs_dp.sv -----
`timescale 1ns / 1ps

module kvs_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  kvs_pkg::cmd_t                    cmd,
	output kvs_pkg::sts_t                    sts,
	input  logic [kvs_pkg::SLOT_W-1:0]       key_index,
	input  logic [kvs_pkg::TIME_W-1:0]       time_value,
	input  logic signed [kvs_pkg::VAL_W-1:0] value_x,
	input  logic signed [kvs_pkg::VAL_W-1:0] value_y,
	input  logic signed [kvs_pkg::VAL_W-1:0] value_z,
	output logic signed [kvs_pkg::VAL_W-1:0] result_x,
	output logic signed [kvs_pkg::VAL_W-1:0] result_y,
	output logic signed [kvs_pkg::VAL_W-1:0] result_z,
	output logic [kvs_pkg::SLOT_W-1:0]       lower_slot,
	output logic [1:0]                       status
);

	logic [kvs_pkg::TIME_W-1:0]          tmem [kvs_pkg::MAX_KEYS];
	logic [kvs_pkg::NCOMP*kvs_pkg::VAL_W-1:0] vmem [kvs_pkg::MAX_KEYS];

	logic [kvs_pkg::TIME_W-1:0]          rd_time_q;
	logic [kvs_pkg::NCOMP*kvs_pkg::VAL_W-1:0] rd_vec_q;
	logic [kvs_pkg::TIME_W-1:0]          sample_t_q;
	logic [kvs_pkg::TIME_W-1:0]          prev_q;
	logic [kvs_pkg::TIME_W-1:0]          rem_q;
	logic [kvs_pkg::TIME_W-1:0]          den_q;
	logic [kvs_pkg::W_W-1:0]             w_q;
	logic [kvs_pkg::VAL_W-1:0]           va_q   [kvs_pkg::NCOMP];
	logic [kvs_pkg::DIFF_W-1:0]          diff_q [kvs_pkg::NCOMP];
	logic [kvs_pkg::VAL_W-1:0]           res_q  [kvs_pkg::NCOMP];
	logic signed [kvs_pkg::PROD_W-1:0]   prod_s1;
	logic [kvs_pkg::VAL_W-1:0]           a_s1;
	logic [kvs_pkg::COMP_W-1:0]          comp_s1;
	logic                                pv_s1;
	logic [kvs_pkg::TIME_W:0]            shl;
	logic [kvs_pkg::TIME_W:0]            sub;
	logic [kvs_pkg::VAL_W-1:0]           vb [kvs_pkg::NCOMP];
	logic [kvs_pkg::VAL_W-1:0]           rv [kvs_pkg::NCOMP];

	// key memories: one write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.key_wr && ({1'b0, key_index} < (kvs_pkg::SLOT_W+1)'(kvs_pkg::MAX_KEYS))) begin
			tmem[kvs_pkg::KEY_AW'(key_index)] <= time_value;
			vmem[kvs_pkg::KEY_AW'(key_index)] <= {value_x, value_y, value_z};
		end
		if (cmd.t_rd) begin
			rd_time_q <= tmem[cmd.rd_addr];
		end
		if (cmd.v_rd) begin
			rd_vec_q <= vmem[cmd.rd_addr];
		end
	end

	// split the read vector into components
	always_comb begin
		rv[0] = rd_vec_q[3*kvs_pkg::VAL_W-1:2*kvs_pkg::VAL_W];
		rv[1] = rd_vec_q[2*kvs_pkg::VAL_W-1:kvs_pkg::VAL_W];
		rv[2] = rd_vec_q[kvs_pkg::VAL_W-1:0];
		vb    = rv;
	end

	// segment compares
	assign sts.le_first = sample_t_q <= rd_time_q;
	assign sts.hit      = (prev_q <= sample_t_q) && (sample_t_q < rd_time_q);

	// restoring divider step, one weight bit per cycle
	assign shl = {rem_q, 1'b0};
	assign sub = shl - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sample_t_q <= time_value;
		end
		if (cmd.prev_ld) begin
			prev_q <= rd_time_q;
		end
		if (cmd.start) begin
			w_q <= '0;
		end else if (cmd.div_init) begin
			rem_q <= sample_t_q - prev_q;
			den_q <= rd_time_q - prev_q;
			w_q   <= '0;
		end else if (cmd.div_step) begin
			if (!sub[kvs_pkg::TIME_W]) begin
				rem_q <= sub[kvs_pkg::TIME_W-1:0];
				w_q   <= {w_q[kvs_pkg::W_W-2:0], 1'b1};
			end else begin
				rem_q <= shl[kvs_pkg::TIME_W-1:0];
				w_q   <= {w_q[kvs_pkg::W_W-2:0], 1'b0};
			end
		end
	end

	// end keys and their difference
	always_ff @(posedge clk) begin
		for (int k = 0; k < kvs_pkg::NCOMP; k++) begin
			if (cmd.va_ld) begin
				va_q[k] <= rv[k];
			end
			if (cmd.vb_ld) begin
				diff_q[k] <= {vb[k][kvs_pkg::VAL_W-1], vb[k]} -
					{va_q[k][kvs_pkg::VAL_W-1], va_q[k]};
			end
		end
	end

	// blend: one component per cycle through the shared multiplier
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= $signed(diff_q[cmd.comp]) * $signed({1'b0, w_q});
			a_s1    <= va_q[cmd.comp];
			comp_s1 <= cmd.comp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_res) begin
			for (int k = 0; k < kvs_pkg::NCOMP; k++) begin
				res_q[k] <= '0;
			end
		end else if (pv_s1) begin
			res_q[comp_s1] <= a_s1 + prod_s1[kvs_pkg::W_W+kvs_pkg::VAL_W-1:kvs_pkg::W_W];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_x   <= res_q[0];
			result_y   <= res_q[1];
			result_z   <= res_q[2];
			lower_slot <= cmd.out_slot;
			status     <= cmd.out_status;
		end
	end

endmodule

// ----- rtl/core/kvs_ctrl.sv -----
`timescale 1ns / 1ps

module kvs_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [kvs_pkg::CNT_W-1:0] cfg_data,
	input  logic                      in_valid,
	input  logic                      in_op,
	output logic                      in_ready,
	input  logic                      out_ready,
	output logic                      out_valid,
	input  kvs_pkg::sts_t             sts,
	output kvs_pkg::cmd_t             cmd
);

	kvs_pkg::state_t                 state_q, state_d;
	logic [kvs_pkg::CNT_W-1:0]       key_count_q;
	logic [kvs_pkg::NUM_W-1:0]       n_q, n_d;
	logic [kvs_pkg::NUM_W-1:0]       idx_q, idx_d;
	logic [kvs_pkg::NUM_W-1:0]       idx_inc;
	logic [kvs_pkg::KEY_AW-1:0]      lo_q, lo_d;
	logic [kvs_pkg::KEY_AW-1:0]      hi_q, hi_d;
	kvs_pkg::status_t                status_q, status_d;
	logic [kvs_pkg::DIV_CW-1:0]      dcnt_q, dcnt_d;
	logic [kvs_pkg::COMP_W-1:0]      comp_q, comp_d;
	logic                            out_valid_q, out_valid_d;
	logic [kvs_pkg::NUM_W-1:0]       n_cfg;
	logic [kvs_pkg::KEY_AW-1:0]      last;

	// clamp the configured count to the table size
	assign n_cfg = (key_count_q > kvs_pkg::CNT_W'(kvs_pkg::MAX_KEYS)) ?
		kvs_pkg::NUM_W'(kvs_pkg::MAX_KEYS) : kvs_pkg::NUM_W'(key_count_q);
	assign idx_inc  = idx_q + 1'b1;
	assign last     = kvs_pkg::KEY_AW'(n_q - 1'b1);
	assign out_valid = out_valid_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
		end else if (cfg_we) begin
			key_count_q <= cfg_data;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kvs_pkg::S_IDLE;
			n_q         <= '0;
			idx_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			status_q    <= kvs_pkg::ST_INTERP;
			dcnt_q      <= '0;
			comp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			n_q         <= n_d;
			idx_q       <= idx_d;
			lo_q        <= lo_d;
			hi_q        <= hi_d;
			status_q    <= status_d;
			dcnt_q      <= dcnt_d;
			comp_q      <= comp_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		n_d         = n_q;
		idx_d       = idx_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		status_d    = status_q;
		dcnt_d      = dcnt_q;
		comp_d      = comp_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.comp    = comp_q;
		cmd.out_slot   = kvs_pkg::SLOT_W'(lo_q);
		cmd.out_status = status_q;
		out_valid_d = out_valid_q && !out_ready;

		case (state_q)
			kvs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == kvs_pkg::OP_WRITE) begin
						cmd.key_wr = 1'b1;
					end else begin
						cmd.start = 1'b1;
						n_d       = n_cfg;
						idx_d     = kvs_pkg::NUM_W'(1);
						lo_d      = '0;
						hi_d      = '0;
						if (n_cfg == '0) begin
							cmd.clr_res = 1'b1;
							status_d    = kvs_pkg::ST_EMPTY;
							state_d     = kvs_pkg::S_DONE;
						end else begin
							cmd.t_rd    = 1'b1;
							cmd.rd_addr = '0;
							state_d     = kvs_pkg::S_CHK0;
						end
					end
				end
			end
			kvs_pkg::S_CHK0: begin
				cmd.prev_ld = 1'b1;
				if (sts.le_first) begin
					status_d = kvs_pkg::ST_BEFORE;
					state_d  = kvs_pkg::S_VA;
				end else if (n_q == kvs_pkg::NUM_W'(1)) begin
					status_d = kvs_pkg::ST_AFTER;
					state_d  = kvs_pkg::S_VA;
				end else begin
					cmd.t_rd    = 1'b1;
					cmd.rd_addr = idx_q[kvs_pkg::KEY_AW-1:0];
					state_d     = kvs_pkg::S_SCAN;
				end
			end
			kvs_pkg::S_SCAN: begin
				if (sts.hit) begin
					cmd.div_init = 1'b1;
					lo_d     = kvs_pkg::KEY_AW'(idx_q - 1'b1);
					hi_d     = idx_q[kvs_pkg::KEY_AW-1:0];
					status_d = kvs_pkg::ST_INTERP;
					dcnt_d   = '0;
					state_d  = kvs_pkg::S_DIV;
				end else begin
					cmd.prev_ld = 1'b1;
					if (idx_inc == n_q) begin
						lo_d     = last;
						hi_d     = last;
						status_d = kvs_pkg::ST_AFTER;
						state_d  = kvs_pkg::S_VA;
					end else begin
						cmd.t_rd    = 1'b1;
						cmd.rd_addr = idx_inc[kvs_pkg::KEY_AW-1:0];
						idx_d       = idx_inc;
					end
				end
			end
			kvs_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				dcnt_d       = dcnt_q + 1'b1;
				if (dcnt_q == kvs_pkg::DIV_CW'(kvs_pkg::W_W - 1)) begin
					state_d = kvs_pkg::S_VA;
				end
			end
			kvs_pkg::S_VA: begin
				cmd.v_rd    = 1'b1;
				cmd.rd_addr = lo_q;
				state_d     = kvs_pkg::S_VB;
			end
			kvs_pkg::S_VB: begin
				cmd.va_ld   = 1'b1;
				cmd.v_rd    = 1'b1;
				cmd.rd_addr = hi_q;
				state_d     = kvs_pkg::S_VW;
			end
			kvs_pkg::S_VW: begin
				cmd.vb_ld = 1'b1;
				comp_d    = '0;
				state_d   = kvs_pkg::S_MUL;
			end
			kvs_pkg::S_MUL: begin
				cmd.mul_en = 1'b1;
				comp_d     = comp_q + 1'b1;
				if (comp_q == kvs_pkg::COMP_W'(kvs_pkg::NCOMP - 1)) begin
					state_d = kvs_pkg::S_FIN;
				end
			end
			kvs_pkg::S_FIN: begin
				state_d = kvs_pkg::S_DONE;
			end
			kvs_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = kvs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kvs_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- verif/kvs_sample_checker.sv -----
`timescale 1ns / 1ps

module kvs_sample_checker
	import kvs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	kvs_in_if                key_mon,
	kvs_out_if               res_mon,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] y;
		logic signed [VAL_W-1:0] z;
		logic [SLOT_W-1:0]       slot;
		status_t                 status;
	} sample_t;

	// shadow copy of the key table and the count register
	logic [TIME_W-1:0]       key_time [MAX_KEYS];
	logic signed [VAL_W-1:0] key_x    [MAX_KEYS];
	logic signed [VAL_W-1:0] key_y    [MAX_KEYS];
	logic signed [VAL_W-1:0] key_z    [MAX_KEYS];
	logic [CNT_W-1:0]        live_count;

	// newest prediction at the front, oldest at the back
	sample_t expected_samples [$];
	sample_t want;

	initial begin
		fail_count = 0;
		pending    = 0;
		live_count = '0;
	end

	// convex blend of two components, floor of the Q0.16 weighted sum
	function automatic logic signed [VAL_W-1:0] mix(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b, input int w);
		longint acc;
		acc = longint'(a) * longint'(65536 - w) + longint'(b) * longint'(w);
		return VAL_W'(acc >>> 16);
	endfunction

	// segment search and interpolation for one sample time
	function automatic sample_t interp_sample(input logic [TIME_W-1:0] t);
		sample_t     s;
		int          n;
		int          lo;
		int          hi;
		int          w;
		bit          found;
		logic [47:0] num;
		logic [47:0] den;
		n     = (live_count > MAX_KEYS) ? MAX_KEYS : int'(live_count);
		lo    = 0;
		hi    = 0;
		w     = 0;
		found = 1'b0;
		if (n == 0) begin
			s.x      = '0;
			s.y      = '0;
			s.z      = '0;
			s.slot   = '0;
			s.status = ST_EMPTY;
			return s;
		end
		if (t <= key_time[0]) begin
			s.status = ST_BEFORE;
		end else begin
			// no matching segment leaves the last key
			s.status = ST_AFTER;
			lo = n - 1;
			hi = n - 1;
			for (int i = 0; i + 1 < n && !found; i++) begin
				if (key_time[i] <= t && t < key_time[i+1]) begin
					num      = {t - key_time[i], 16'd0};
					den      = {16'd0, key_time[i+1] - key_time[i]};
					w        = int'(num / den);
					lo       = i;
					hi       = i + 1;
					s.status = ST_INTERP;
					found    = 1'b1;
				end
			end
		end
		s.x    = mix(key_x[lo], key_x[hi], w);
		s.y    = mix(key_y[lo], key_y[hi], w);
		s.z    = mix(key_z[lo], key_z[hi], w);
		s.slot = SLOT_W'(lo);
		return s;
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_count = '0;
			expected_samples.delete();
			pending = 0;
		end else begin
			if (cfg_we)
				live_count = cfg_data;

			// input transaction: key write or sample request
			if (key_mon.valid && key_mon.ready) begin
				if (key_mon.operation == OP_WRITE) begin
					key_time[key_mon.key_index] = key_mon.time_value;
					key_x[key_mon.key_index]    = key_mon.value_x;
					key_y[key_mon.key_index]    = key_mon.value_y;
					key_z[key_mon.key_index]    = key_mon.value_z;
				end else begin
					expected_samples.push_front(interp_sample(key_mon.time_value));
				end
			end

			// result transaction against the oldest prediction
			if (res_mon.valid && res_mon.ready) begin
				if (expected_samples.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: x=%h y=%h z=%h slot=%0d status=%0d",
							res_mon.result_x, res_mon.result_y, res_mon.result_z,
							res_mon.lower_slot, res_mon.status);
				end else begin
					want = expected_samples.pop_back();
					if (res_mon.result_x !== want.x || res_mon.result_y !== want.y ||
							res_mon.result_z !== want.z || res_mon.lower_slot !== want.slot ||
							res_mon.status !== want.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: expected x=%h y=%h z=%h slot=%0d status=%0d,",
								" got x=%h y=%h z=%h slot=%0d status=%0d"},
								want.x, want.y, want.z, want.slot, want.status,
								res_mon.result_x, res_mon.result_y, res_mon.result_z,
								res_mon.lower_slot, res_mon.status);
					end
				end
			end

			pending = expected_samples.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import kvs_pkg::*;

	localparam int CLK_HALF    = 2;
	localparam int RUN_ITEMS   = 450;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 100;
	localparam int HOLD_CYCLES = 400;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             cfg_we   = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;

	kvs_in_if  key_bus ();
	kvs_out_if res_bus ();

	int fail_count;
	int pending;

	// stimulus side bookkeeping
	logic [TIME_W-1:0] tab_time [MAX_KEYS];
	int                live;
	int                items_sent = 0;
	bit                steady_send = 1'b0;
	int                hold_asks = 0;
	int                hold_served = 0;
	int                cycles = 0;

	keyframe_vector_sampler u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.key_in     (key_bus),
		.sample_out (res_bus)
	);

	kvs_sample_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.key_mon    (key_bus),
		.res_mon    (res_bus),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #CLK_HALF clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// offer one transaction after a random gap, return at its acceptance edge
	task automatic put_item(input logic op, input logic [SLOT_W-1:0] idx,
			input logic [TIME_W-1:0] t, input logic [VAL_W-1:0] x,
			input logic [VAL_W-1:0] y, input logic [VAL_W-1:0] z);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (steady_send || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else if (r < 98)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(30, 80);
		if (gap > 0) begin
			key_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_bus.valid      <= 1'b1;
		key_bus.operation  <= op;
		key_bus.key_index  <= idx;
		key_bus.time_value <= t;
		key_bus.value_x    <= x;
		key_bus.value_y    <= y;
		key_bus.value_z    <= z;
		@(posedge clk iff key_bus.ready);
		items_sent++;
	endtask

	task automatic write_key(input logic [SLOT_W-1:0] idx, input logic [TIME_W-1:0] t,
			input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y,
			input logic [VAL_W-1:0] z);
		put_item(OP_WRITE, idx, t, x, y, z);
		tab_time[idx] = t;
	endtask

	// ignored fields carry random content
	task automatic sample_at(input logic [TIME_W-1:0] t);
		put_item(OP_SAMPLE, SLOT_W'($urandom), t, $urandom, $urandom, $urandom);
	endtask

	// wait until every sample has returned and in-flight work has settled
	task automatic drain();
		key_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_count(input int v);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= CNT_W'(v);
		@(posedge clk);
		cfg_we   <= 1'b0;
		live = (v > MAX_KEYS) ? MAX_KEYS : v;
	endtask

	// receiver: random stalls, steady stretches and the one long hold-off
	initial begin
		int len;
		int r;
		bit level;
		res_bus.ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_served != hold_asks) begin
				hold_served++;
				level = 1'b0;
				len   = HOLD_CYCLES;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					level = 1'b1;
					len   = $urandom_range(1, 12);
				end else if (r < 58) begin
					level = 1'b1;
					len   = $urandom_range(60, 250);
				end else if (r < 92) begin
					level = 1'b0;
					len   = $urandom_range(1, 3);
				end else begin
					level = 1'b0;
					len   = $urandom_range(15, 60);
				end
			end
			repeat (len) begin
				@(posedge clk);
				res_bus.ready <= level;
			end
		end
	end

	// stimulus and verdict
	initial begin
		int                r;
		int                mode;
		int                cnt;
		int                nsamp;
		int                i;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] lo;
		logic [TIME_W-1:0] hi;
		logic [TIME_W:0]   acc;
		logic [TIME_W-1:0] incr;

		key_bus.valid      = 1'b0;
		key_bus.operation  = OP_WRITE;
		key_bus.key_index  = '0;
		key_bus.time_value = '0;
		key_bus.value_x    = '0;
		key_bus.value_y    = '0;
		key_bus.value_z    = '0;
		live               = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		sample_at(32'h0000_0000);
		sample_at(32'hFFFF_FFFF);

		// single key: before, on and after it
		write_key(SLOT_W'(0), 32'h0000_0100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		set_count(1);
		sample_at(32'h0000_0000);
		sample_at(32'h0000_0100);
		sample_at(32'h0000_0101);

		// extreme values on the first segment, unordered tail
		write_key(SLOT_W'(1), 32'h0000_0200, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		write_key(SLOT_W'(2), 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
		write_key(SLOT_W'(3), 32'h0000_0050, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000);
		set_count(4);
		sample_at(32'h0000_0180);
		sample_at(32'h0000_01FF);
		sample_at(32'h0000_0200);
		sample_at(32'hFFFF_FFFE);
		sample_at(32'hFFFF_FFFF);
		sample_at(32'h0000_0080);

		// time exactly on the last key
		set_count(3);
		sample_at(32'hFFFF_FFFF);
		write_key(SLOT_W'(63), $urandom, $urandom, $urandom, $urandom);

		// random phases, each with a fresh table
		while (items_sent < RUN_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				cnt = 0;
			else if (r < 16)
				cnt = 1;
			else if (r < 70)
				cnt = $urandom_range(2, 8);
			else if (r < 88)
				cnt = $urandom_range(9, 24);
			else if (r < 94)
				cnt = MAX_KEYS;
			else
				cnt = $urandom_range(MAX_KEYS + 1, (1 << CNT_W) - 1);
			set_count(cnt);
			steady_send = ($urandom_range(0, 3) == 0);

			// table: mostly ascending, some with repeats, some scrambled
			mode = $urandom_range(0, 99);
			r = $urandom_range(0, 3);
			if (r == 0)
				t = '0;
			else if (r == 1)
				t = $urandom_range(0, 4096);
			else
				t = $urandom & 32'h7FFF_FFFF;
			for (i = 0; i < live; i++) begin
				if (mode >= 90)
					t = $urandom;
				write_key(SLOT_W'(i), t, $urandom, $urandom, $urandom);
				r = $urandom_range(0, 99);
				if (mode >= 80)
					incr = $urandom_range(0, 3);
				else if (r < 10)
					incr = 1;
				else if (r < 60)
					incr = $urandom_range(1, 256);
				else if (r < 90)
					incr = $urandom_range(257, 65535);
				else
					incr = $urandom_range(1, 1 << 25);
				acc = t + incr;
				t = acc[TIME_W] ? '1 : acc[TIME_W-1:0];
			end

			// one long receiver hold-off while samples keep coming
			if (hold_asks == 0 && items_sent > 150 && live >= 2)
				hold_asks++;

			nsamp = $urandom_range(4, 16);
			repeat (nsamp) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					write_key(SLOT_W'($urandom_range(0, MAX_KEYS - 1)), $urandom, $urandom,
						$urandom, $urandom);
				end else begin
					if (live == 0 || r >= 90) begin
						t = $urandom;
					end else if (live >= 2 && r < 70) begin
						i  = $urandom_range(0, live - 2);
						lo = tab_time[i];
						hi = tab_time[i+1];
						t  = (hi > lo) ? lo + $urandom_range(0, hi - lo - 1) : lo;
					end else if (r < 80) begin
						t = tab_time[$urandom_range(0, live - 1)];
					end else begin
						case ($urandom_range(0, 3))
							0:       t = '0;
							1:       t = '1;
							2:       t = tab_time[0] - 1;
							default: t = tab_time[live-1] + 1;
						endcase
					end
					sample_at(t);
				end
			end
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/kvs_pkg.sv
rtl/core/kvs_in_if.sv
rtl/core/kvs_out_if.sv
rtl/core/kvs_dp.sv
rtl/core/kvs_ctrl.sv
rtl/core/keyframe_vector_sampler.sv
verif/kvs_sample_checker.sv
verif/testbench.sv
